// ===== rtl/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants of the LRU key-value cache
// Holds the beat payload structs, the command/status bundles between the
// controller and the datapath, and the fixed field widths and codes.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried in the func field
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                           func;
    logic        [KEY_FIELD_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0]       store_value;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the accepted beat
    logic capture;  // register the lookup results
    logic get_hit;  // read the hit value and make the entry most recent
    logic put_hit;  // overwrite the hit value and make the entry most recent
    logic evict;    // drop the least recent entry
    logic insert;   // store the new key in a free slot
    logic respond;  // result beat on the output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic func;
    logic hit;
    logic need_evict;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_ACT   = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

endpackage

// ===== rtl/lrukv_ram.sv =====
// ----------------------------------------------------------------------------
// lrukv_ram: generic single-port RAM
// One read, with an optional write, per cycle at one address; read data is registered.
// ----------------------------------------------------------------------------
module lrukv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrukv_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrukv_ctrl: sequencing controller of the LRU key-value cache
// Steps each beat through lookup, action and, for a get, response; loops on eviction.
// ----------------------------------------------------------------------------
module lrukv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lrukv_pkg::status_t status_i,
  output lrukv_pkg::cmd_t    cmd_o
);

  lrukv_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      lrukv_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = lrukv_pkg::ST_MATCH;
        end
      end
      lrukv_pkg::ST_MATCH: begin
        cmd_o.capture = 1'b1;
        state_d       = lrukv_pkg::ST_ACT;
      end
      lrukv_pkg::ST_ACT: begin
        if (status_i.func == lrukv_pkg::FUNC_GET) begin
          cmd_o.get_hit = status_i.hit;
          state_d       = lrukv_pkg::ST_RESP;
        end else if (status_i.hit) begin
          cmd_o.put_hit = 1'b1;
          state_d       = lrukv_pkg::ST_IDLE;
        end else if (status_i.need_evict) begin
          // drop one entry, then redo the lookup against the new occupancy
          cmd_o.evict = 1'b1;
          state_d     = lrukv_pkg::ST_MATCH;
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = lrukv_pkg::ST_IDLE;
        end
      end
      lrukv_pkg::ST_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = lrukv_pkg::ST_IDLE;
      end
      default: begin
        state_d = lrukv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrukv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != lrukv_pkg::ST_IDLE);

endmodule

// ===== rtl/lrukv_dp.sv =====
// ----------------------------------------------------------------------------
// lrukv_dp: datapath of the LRU key-value cache
// Key cells with parallel compare, per-entry recency ranks, value RAM,
// occupancy count and the capacity register.
// ----------------------------------------------------------------------------
module lrukv_dp #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lrukv_pkg::cmd_t                   cmd_i,
  output lrukv_pkg::status_t                status_o,
  input  lrukv_pkg::in_item_t               in_item_i,
  input  logic                              cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]       cfg_wdata_i,
  output lrukv_pkg::out_item_t              out_item_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = OCC_W + lrukv_pkg::CAP_W;

  logic                          func_q;
  logic [KEY_WIDTH-1:0]          key_q;
  logic [VALUE_WIDTH-1:0]        val_q;
  logic [KEY_WIDTH+31:0]         key_ext;
  logic signed [VALUE_WIDTH+31:0] val_ext;
  logic signed [VALUE_WIDTH+31:0] rd_ext;

  logic [KEY_WIDTH-1:0]          keys_q [ENTRIES];
  logic [ENTRIES-1:0]            valid_q;
  logic [IDX_W-1:0]              rank_q [ENTRIES];
  logic [OCC_W-1:0]              occ_q;
  logic [OCC_W-1:0]              occ_last;
  logic [lrukv_pkg::CAP_W-1:0]   cap_q;

  logic                          hit_d, hit_q;
  logic [IDX_W-1:0]              hit_idx_d, hit_idx_q;
  logic [IDX_W-1:0]              hit_rank_d, hit_rank_q;
  logic [IDX_W-1:0]              lru_idx_d, lru_idx_q;
  logic [IDX_W-1:0]              free_idx_d, free_idx_q;
  logic                          need_evict_d, need_evict_q;
  logic                          touch;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_addr;
  logic [VALUE_WIDTH-1:0]        ram_rdata;

  // keep the key at KEY_WIDTH bits, the value sign-extended to VALUE_WIDTH
  assign key_ext  = {KEY_WIDTH'(1'b0), in_item_i.lookup_key};
  assign val_ext  = (VALUE_WIDTH + 32)'(in_item_i.store_value);
  assign occ_last = occ_q - OCC_W'(1);
  assign touch    = cmd_i.get_hit | cmd_i.put_hit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_item_i.func;
      key_q  <= key_ext[KEY_WIDTH-1:0];
      val_q  <= val_ext[VALUE_WIDTH-1:0];
    end
  end

  // parallel compare over all cells; at most one hit and one least-recent match, lowest free cell chosen
  always_comb begin
    hit_d      = 1'b0;
    hit_idx_d  = '0;
    hit_rank_d = '0;
    lru_idx_d  = '0;
    free_idx_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (keys_q[i] == key_q)) begin
        hit_d      = 1'b1;
        hit_idx_d  = hit_idx_d | IDX_W'(i);
        hit_rank_d = hit_rank_d | rank_q[i];
      end
      if (valid_q[i] && (OCC_W'(rank_q[i]) == occ_last)) begin
        lru_idx_d = lru_idx_d | IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx_d = IDX_W'(i);
      end
    end
  end

  // capacity 0 acts as 1 and anything above ENTRIES as ENTRIES
  assign need_evict_d = (occ_q != '0) &&
                        ((occ_q == OCC_W'(ENTRIES)) ||
                         (CMP_W'(occ_q) >= CMP_W'(cap_q)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_idx_q    <= hit_idx_d;
      hit_rank_q   <= hit_rank_d;
      lru_idx_q    <= lru_idx_d;
      free_idx_q   <= free_idx_d;
      need_evict_q <= need_evict_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lrukv_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      keys_q[free_idx_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cmd_i.insert) begin
        valid_q[free_idx_q] <= 1'b1;
        occ_q               <= occ_q + OCC_W'(1);
      end else if (cmd_i.evict) begin
        valid_q[lru_idx_q] <= 1'b0;
        occ_q              <= occ_last;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (touch) begin
          if (hit_idx_q == IDX_W'(i)) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end else if (cmd_i.insert) begin
          if (free_idx_q == IDX_W'(i)) begin
            rank_q[i] <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end else if (cmd_i.evict && (lru_idx_q == IDX_W'(i))) begin
          rank_q[i] <= '0;
        end
      end
    end
  end

  assign ram_we   = cmd_i.put_hit | cmd_i.insert;
  assign ram_addr = cmd_i.insert ? free_idx_q : hit_idx_q;

  lrukv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  assign rd_ext = (VALUE_WIDTH + 32)'($signed(ram_rdata));

  assign out_item_o.found      = hit_q;
  assign out_item_o.read_value = hit_q ? rd_ext[lrukv_pkg::DATA_W-1:0]
                                       : lrukv_pkg::MISS_VALUE;

  assign status_o.func       = func_q;
  assign status_o.hit        = hit_q;
  assign status_o.need_evict = need_evict_q;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Get: the beat runs through the match, act and respond states, and the
// result beat is strobed in the respond state; a new start is taken once
// the block is back in idle. Put: match and act, with a further match and
// act for each evicted entry when the key is new.
// Reset clears valid marks, ranks, occupancy; capacity returns to 16. There
// is no clearing pass. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command side: a beat is taken when start is high and busy is low
  input  logic                         start,
  output logic                         busy,
  input  lrukv_pkg::in_item_t          in_item_i,
  // result side: one beat per get, valid for the single strobe cycle
  output logic                         out_strobe_o,
  output lrukv_pkg::out_item_t         out_item_o,
  // capacity register write
  input  logic                         cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]  cfg_wdata_i
);

  lrukv_pkg::cmd_t    cmd;
  lrukv_pkg::status_t status;

  // Controller: walks each beat through lookup (all keys compared at once),
  // action (read, overwrite, evict or insert) and, for a get, the response.
  lrukv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath: key cells, recency ranks (0 = most recent), occupancy, values.
  lrukv_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

  // Hold the strobe to the response step only.
  assign out_strobe_o = cmd.respond;

  // A result beat only comes out of an item still in flight.
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> busy)
    else $error("result strobe while idle");

  // An accepted beat keeps the block busy and yields no result next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !out_strobe_o))
    else $error("accepted beat did not start the sequence");

  // One result per get: the strobe is not held high.
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |=> !out_strobe_o)
    else $error("result strobe held for more than one cycle");

  // A miss always reports the all-ones value.
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !out_item_o.found) |-> (out_item_o.read_value == lrukv_pkg::MISS_VALUE))
    else $error("miss returned a stored value");

endmodule
